// File: rtl/core/swq_pkg.sv
package swq_pkg;

    // Field widths fixed by the word format
    localparam int TICK_W = 63;
    localparam int KIND_W = 2;

    // Operation codes of an input word
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WOKEN  = 2'd2;

    // Write source and slot for the entry memory
    typedef enum logic [1:0] {
        WR_SHIFT     = 2'd0,   // move the entry read at k up to k+1
        WR_NEW_ABOVE = 2'd1,   // new sleeper goes to k+1
        WR_NEW_AT    = 2'd2    // new sleeper goes to k
    } swq_wr_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              in_load;    // capture the accepted input word
        logic              k_load;     // k = count - 1
        logic              k_dec;      // k = k - 1
        logic              k_clear;    // k = 0
        logic              wr_en;
        swq_wr_sel_t       wr_sel;
        logic              count_inc;  // one sleeper added
        logic              pop;        // front sleeper removed
        logic              pend_load;  // hold front id as pending wake-up
        logic              res_load;   // load the result register
        logic [KIND_W-1:0] res_kind;
        logic              res_last;
    } swq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic count_zero;
        logic k_zero;
        logic gt_wake;   // entry read is later than the inserted tick
        logic le_now;    // entry read is due at the current time
    } swq_status_t;

endpackage

// File: rtl/core/swq_datapath.sv
module swq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swq_pkg::swq_cmd_t              cmd,
    output swq_pkg::swq_status_t           status,
    input  logic [swq_pkg::TICK_W-1:0]     wake_tick,
    input  logic [ID_BITS-1:0]             sleeper_id,
    input  logic [swq_pkg::TICK_W-1:0]     now_tick,
    output logic [swq_pkg::KIND_W-1:0]     kind,
    output logic [ID_BITS-1:0]             woken_id,
    output logic                           last
);
    import swq_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = 2 ** PTR_W;
    localparam int ENTRY_W   = TICK_W + ID_BITS;

    // Entry memory, circular, indexed from the head pointer
    logic [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   count_m1;

    logic [TICK_W-1:0]  wake_reg, now_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] pend_id_reg;

    logic [KIND_W-1:0]  kind_reg;
    logic [ID_BITS-1:0] woken_id_reg;
    logic               last_reg;

    logic [TICK_W-1:0]  rd_tick;
    logic [ID_BITS-1:0] rd_id;

    assign rd_tick  = rd_data_reg[ENTRY_W-1:ID_BITS];
    assign rd_id    = rd_data_reg[ID_BITS-1:0];
    assign count_m1 = count_reg - CNT_W'(1);

    // Pointer and count updates
    always_comb
    begin
        head_next  = cmd.pop ? head_reg + PTR_W'(1) : head_reg;
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_m1;
        end
        k_next = k_reg;
        if (cmd.k_load)
        begin
            k_next = count_m1[PTR_W-1:0];
        end
        else if (cmd.k_dec)
        begin
            k_next = k_reg - PTR_W'(1);
        end
        else if (cmd.k_clear)
        begin
            k_next = '0;
        end
    end

    // Read address follows the next pointers, so the read data register holds the entry at the current pointers
    assign rd_addr = head_next + k_next;

    // Write slot and data
    always_comb
    begin
        case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_addr = head_reg + k_reg + PTR_W'(1);
                wr_data = rd_data_reg;
            end
            WR_NEW_ABOVE:
            begin
                wr_addr = head_reg + k_reg + PTR_W'(1);
                wr_data = {wake_reg, id_reg};
            end
            WR_NEW_AT:
            begin
                wr_addr = head_reg + k_reg;
                wr_data = {wake_reg, id_reg};
            end
            default:
            begin
                wr_addr = head_reg + k_reg;
                wr_data = {wake_reg, id_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    // Captured input word and pending wake-up
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            wake_reg <= wake_tick;
            now_reg  <= now_tick;
            id_reg   <= sleeper_id;
        end
        if (cmd.pend_load)
        begin
            pend_id_reg <= rd_id;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            kind_reg     <= cmd.res_kind;
            last_reg     <= cmd.res_last;
            woken_id_reg <= (cmd.res_kind == KIND_WOKEN) ? pend_id_reg : '0;
        end
    end

    assign kind     = kind_reg;
    assign woken_id = woken_id_reg;
    assign last     = last_reg;

    // Status back to the controller
    always_comb
    begin
        status.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
        status.count_zero = (count_reg == '0);
        status.k_zero     = (k_reg == '0);
        status.gt_wake    = (rd_tick > wake_reg);
        status.le_now     = (rd_tick <= now_reg);
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> !status.full)
        else $error("insert committed on a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !status.count_zero)
        else $error("pop from an empty queue");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> count_reg == CNT_W'($past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement the count");

    a_no_write_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.pop))
        else $error("memory write during a pop");
`endif

endmodule

// File: rtl/core/swq_ctrl.sv
module swq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  op,
    output logic                  result_valid,
    input  logic                  result_ready,
    output swq_pkg::swq_cmd_t     cmd,
    input  swq_pkg::swq_status_t  status
);
    import swq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_INS_CMP  = 5'b00010,
        S_INS_HEAD = 5'b00100,
        S_TK_CHK   = 5'b01000,
        S_OUT_WAIT = 5'b10000
    } swq_state_t;

    swq_state_t state_reg, state_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       ret_tick_reg, ret_tick_next;
    logic       due;

    assign due = !status.count_zero && status.le_now;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        pend_valid_next = pend_valid_reg;
        ret_tick_next   = ret_tick_reg;
        cmd             = '0;
        cmd.wr_sel      = WR_NEW_AT;
        item_ready      = 1'b0;
        result_valid    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.in_load = 1'b1;
                    if (op == OP_INSERT)
                    begin
                        if (status.full)
                        begin
                            cmd.res_load  = 1'b1;
                            cmd.res_kind  = KIND_REJECT;
                            cmd.res_last  = 1'b1;
                            ret_tick_next = 1'b0;
                            state_next    = S_OUT_WAIT;
                        end
                        else if (status.count_zero)
                        begin
                            cmd.k_clear = 1'b1;
                            state_next  = S_INS_HEAD;
                        end
                        else
                        begin
                            cmd.k_load = 1'b1;
                            state_next = S_INS_CMP;
                        end
                    end
                    else
                    begin
                        cmd.k_clear     = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_TK_CHK;
                    end
                end
            end

            // Walk down from the tail, moving later entries up one slot
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (status.gt_wake)
                begin
                    cmd.wr_sel = WR_SHIFT;
                    if (status.k_zero)
                    begin
                        state_next = S_INS_HEAD;
                    end
                    else
                    begin
                        cmd.k_dec = 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_sel    = WR_NEW_ABOVE;
                    cmd.count_inc = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_kind  = KIND_ACCEPT;
                    cmd.res_last  = 1'b1;
                    ret_tick_next = 1'b0;
                    state_next    = S_OUT_WAIT;
                end
            end

            // New sleeper goes to the front slot
            S_INS_HEAD:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_NEW_AT;
                cmd.count_inc = 1'b1;
                cmd.res_load  = 1'b1;
                cmd.res_kind  = KIND_ACCEPT;
                cmd.res_last  = 1'b1;
                ret_tick_next = 1'b0;
                state_next    = S_OUT_WAIT;
            end

            // Pop due entries one ahead, so the last flag is known on emit
            S_TK_CHK:
            begin
                if (!pend_valid_reg)
                begin
                    if (due)
                    begin
                        cmd.pend_load   = 1'b1;
                        cmd.pop         = 1'b1;
                        pend_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = KIND_WOKEN;
                    cmd.res_last = !due;
                    if (due)
                    begin
                        cmd.pend_load = 1'b1;
                        cmd.pop       = 1'b1;
                        ret_tick_next = 1'b1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        ret_tick_next   = 1'b0;
                    end
                    state_next = S_OUT_WAIT;
                end
            end

            S_OUT_WAIT:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    state_next = ret_tick_reg ? S_TK_CHK : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            ret_tick_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            ret_tick_reg   <= ret_tick_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_WAIT && !result_ready) |=> state_reg == S_OUT_WAIT)
        else $error("result dropped before it was taken");

    a_emit_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.res_kind == KIND_WOKEN) |-> pend_valid_reg)
        else $error("wake-up emitted with no pending sleeper");

    a_return_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_WAIT && ret_tick_reg) |-> pend_valid_reg)
        else $error("tick resumes without a pending sleeper");
`endif

endmodule

// File: rtl/core/sorted_wakeup_queue_top.sv
// Sorted wake-up queue: holds up to QUEUE_DEPTH sleepers ordered by wake tick,
// equal ticks leaving in arrival order. An insert word (op 0) returns one
// result, accepted or rejected when full; a tick word (op 1) returns one woken
// result per due sleeper in ascending order, the final one flagged by last,
// and no result when nothing is due. One word is handled at a time. Entries
// live in a single-port-write circular memory, so an insert walks down from
// the tail one slot per cycle, moving each later entry up (at most
// QUEUE_DEPTH - 1), then holds its one result until result_ready. A tick
// passes a check state and then a result state, held until result_ready,
// for each woken sleeper; a tick with nothing due leaves the check state
// with no result.
// Stored entries are not cleared after reset; no initialisation pass is run.
module sorted_wakeup_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          op,
    input  logic [swq_pkg::TICK_W-1:0]    wake_tick,
    input  logic [ID_BITS-1:0]            sleeper_id,
    input  logic [swq_pkg::TICK_W-1:0]    now_tick,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [swq_pkg::KIND_W-1:0]    kind,
    output logic [ID_BITS-1:0]            woken_id,
    output logic                          last
);
    import swq_pkg::*;

    swq_cmd_t    cmd;
    swq_status_t status;

    swq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    swq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .wake_tick  (wake_tick),
        .sleeper_id (sleeper_id),
        .now_tick   (now_tick),
        .kind       (kind),
        .woken_id   (woken_id),
        .last       (last)
    );

endmodule
